/* rtl/asp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_pkg
// shared types and constants of the alpha sprite pixel writer
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int PIX_W       = 32;
  localparam int IDX_W       = 16;
  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CHAN_W-1:0] ALPHA_MAX = 8'hFF;

  // input action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_BLEND = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // classified operation carried from front to back
  typedef enum logic [1:0] {
    OP_PUT,
    OP_BLEND,
    OP_READ,
    OP_SKIP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] color;
  } item_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MUL,
    BK_WRITE
  } back_state_t;

endpackage

/* rtl/asp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_front
// takes input beats, forms the frame index, clips and classifies the operation
// ----------------------------------------------------------------------------
module asp_front import asp_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic signed [11:0]  in_base_x,
  input  logic signed [11:0]  in_base_y,
  input  logic [7:0]          in_offset_x,
  input  logic [7:0]          in_offset_y,
  input  logic [PIX_W-1:0]    in_pixel_color,
  input  logic                busy,
  input  logic                q_full,
  output logic                q_push,
  output item_t               q_data
);

  localparam int COORD_W = 14;
  localparam int LIN_W   = 22;
  localparam logic signed [COORD_W-1:0] WIDTH_S  = COORD_W'(FRAME_WIDTH);
  localparam logic signed [COORD_W-1:0] HEIGHT_S = COORD_W'(FRAME_HEIGHT);

  logic                      f_valid_r, f_valid_nxt;
  item_t                     f_item_r, f_item_nxt;
  logic signed [COORD_W-1:0] col, row;
  logic                      in_frame;
  logic [LIN_W-1:0]          lin;
  logic                      accept;

  assign in_stall = busy || (f_valid_r && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid_r && !q_full;
  assign q_data   = f_item_r;

  always_comb begin
    col = {{2{in_base_x[11]}}, in_base_x} + {6'd0, in_offset_x};
    row = {{2{in_base_y[11]}}, in_base_y} + {6'd0, in_offset_y};
    in_frame = !col[COORD_W-1] && (col < WIDTH_S) && !row[COORD_W-1] && (row < HEIGHT_S);
    lin = LIN_W'(row[10:0]) * LIN_W'(FRAME_WIDTH) + LIN_W'(col[10:0]);

    f_item_nxt.idx   = lin[IDX_W-1:0];
    f_item_nxt.color = in_pixel_color;
    case (in_action)
      ACT_PUT:   f_item_nxt.op = OP_PUT;
      ACT_BLEND: f_item_nxt.op = (in_pixel_color[31:24] != '0) ? OP_BLEND : OP_SKIP;
      ACT_READ:  f_item_nxt.op = OP_READ;
      default:   f_item_nxt.op = OP_SKIP;
    endcase
    if (!in_frame) begin
      f_item_nxt.op = OP_SKIP;
    end

    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

/* rtl/asp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module asp_queue import asp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/asp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_back
// frame store with read, blend, write sequence and the result register
// ----------------------------------------------------------------------------
module asp_back import asp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  item_t            q_head,
  output logic             q_pop,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_written,
  output logic [IDX_W-1:0] out_pixel_index,
  output logic [PIX_W-1:0] out_pixel_value
);

  localparam int DEPTH = 1 << IDX_W;

  logic [PIX_W-1:0] store_mem [DEPTH];

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;
  item_t            item_r;
  logic [PIX_W-1:0] rd_data_r;
  logic [SUM_W-1:0] sum_r [3];
  logic [SUM_W-1:0] sum_nxt [3];

  logic             out_valid_r, out_valid_nxt;
  logic             out_written_r;
  logic [IDX_W-1:0] out_index_r;
  logic [PIX_W-1:0] out_value_r;

  logic             out_free;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [PIX_W-1:0] mem_wdata;
  logic             out_load;
  logic             res_written;
  logic [IDX_W-1:0] res_index;
  logic [PIX_W-1:0] res_value;
  logic [PIX_W-1:0] blended;

  assign out_free        = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_written     = out_written_r;
  assign out_pixel_index = out_index_r;
  assign out_pixel_value = out_value_r;

  // products per channel, then divide by 255 on the registered sums
  always_comb begin
    logic [CHAN_W-1:0] a;
    logic [SUM_W-1:0]  pf, pb;
    logic [SUM_W:0]    qc;
    a = item_r.color[31:24];
    blended = '0;
    for (int c = 0; c < 3; c++) begin
      pf = SUM_W'(item_r.color[c*CHAN_W +: CHAN_W]) * SUM_W'(a);
      pb = SUM_W'(rd_data_r[c*CHAN_W +: CHAN_W]) * SUM_W'(ALPHA_MAX - a);
      sum_nxt[c] = pf + pb;
      // floor(s/255) for s up to 255*255
      qc = (SUM_W+1)'(sum_r[c]) + (SUM_W+1)'(1) + (SUM_W+1)'(sum_r[c][SUM_W-1:CHAN_W]);
      blended[c*CHAN_W +: CHAN_W] = qc[SUM_W-1:CHAN_W];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_addr_r == '1) state_nxt = BK_IDLE;
      BK_IDLE:  if (!q_empty && out_free) state_nxt = BK_MUL;
      BK_MUL:   state_nxt = BK_WRITE;
      BK_WRITE: state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  // outputs of the sequence
  always_comb begin
    busy         = 1'b0;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = item_r.idx;
    mem_wdata    = '0;
    out_load     = 1'b0;
    clr_addr_nxt = clr_addr_r;
    res_written  = 1'b0;
    res_index    = '0;
    res_value    = '0;
    case (item_r.op)
      OP_PUT: begin
        res_written = 1'b1;
        res_index   = item_r.idx;
        res_value   = item_r.color;
      end
      OP_BLEND: begin
        res_written = 1'b1;
        res_index   = item_r.idx;
        res_value   = blended;
      end
      OP_READ: begin
        res_index = item_r.idx;
        res_value = rd_data_r;
      end
      default: begin
        res_written = 1'b0;
      end
    endcase
    case (state_r)
      BK_CLEAR: begin
        busy         = 1'b1;
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      BK_IDLE: begin
        q_pop = !q_empty && out_free;
      end
      BK_WRITE: begin
        mem_we    = res_written;
        mem_wdata = res_value;
        out_load  = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_data_r <= store_mem[q_head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
    end
    if (state_r == BK_MUL) begin
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= sum_nxt[c];
      end
    end
    if (out_load) begin
      out_written_r <= res_written;
      out_index_r   <= res_index;
      out_value_r   <= res_value;
    end
  end

endmodule

/* rtl/alpha_sprite_pixel_writer.sv */
// path: input beat, front register, queue slot, back item register and store read, product
//   sums, result register; the back takes no new beat until its read, blend, write sequence
//   on the single write port of the 65536-entry frame store is done
// reset: synchronous, rst_n low; afterwards a clearing pass zeroes all 65536 entries of the
//   frame store, and in_stall stays high until it is done
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_sprite_pixel_writer
// framebuffer pixel writer with opaque put, alpha-blended put and read
// ----------------------------------------------------------------------------
module alpha_sprite_pixel_writer import asp_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [11:0] in_base_x,
  input  logic signed [11:0] in_base_y,
  input  logic [7:0]         in_offset_x,
  input  logic [7:0]         in_offset_y,
  input  logic [PIX_W-1:0]   in_pixel_color,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_written,
  output logic [IDX_W-1:0]   out_pixel_index,
  output logic [PIX_W-1:0]   out_pixel_value
);

  // front to queue
  logic  q_push;
  item_t q_push_data;
  logic  q_full;
  // queue to back
  logic  q_pop;
  item_t q_head;
  logic  q_empty;
  // back is running its clearing pass
  logic  clear_busy;

  // front: coordinate add, clip, index, classify; holds one beat
  asp_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_base_x      (in_base_x),
    .in_base_y      (in_base_y),
    .in_offset_x    (in_offset_x),
    .in_offset_y    (in_offset_y),
    .in_pixel_color (in_pixel_color),
    .busy           (clear_busy),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_push_data)
  );

  // decoupling queue, lets the front keep taking beats while the back works
  asp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: frame store access, blend, write back, result register
  asp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .busy            (clear_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_written     (out_written),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value)
  );

`ifndef SYNTHESIS
  // no result while the store is being cleared
  assert property (@(posedge clk) disable iff (!rst_n) clear_busy |-> !out_valid)
    else $error("result beat during clearing pass");

  // the queue is never pushed while full
  assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
    else $error("queue overflow");

  // the back runs its full sequence for each beat, so result beats are never back to back
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result beats closer than the back sequence allows");
`endif

endmodule

/* verif/asp_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_pixel_checker
// watches both channels of the pixel writer, keeps a shadow framebuffer and
// compares every result beat with the predicted one
// ----------------------------------------------------------------------------
module asp_pixel_checker import asp_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [11:0] in_base_x,
  input  logic signed [11:0] in_base_y,
  input  logic [7:0]         in_offset_x,
  input  logic [7:0]         in_offset_y,
  input  logic [PIX_W-1:0]   in_pixel_color,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_written,
  input  logic [IDX_W-1:0]   out_pixel_index,
  input  logic [PIX_W-1:0]   out_pixel_value,
  output int                 err_count,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    logic             written;
    logic [IDX_W-1:0] index;
    logic [PIX_W-1:0] value;
  } pixel_result_t;

  logic [PIX_W-1:0] frame_model [0:65535];
  pixel_result_t    expected_px [$];
  pixel_result_t    want;

  initial begin
    err_count = 0;
    pending   = 0;
    checked   = 0;
  end

  task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] got,
                               input logic [PIX_W-1:0] exp_val);
    $display("%0t mismatch on %s: got %h, predicted %h", $realtime, what, got, exp_val);
    err_count++;
  endtask

  // per channel: floor((fg*a + bg*(255-a)) / 255), alpha byte of result cleared
  function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] fg,
                                                   input logic [PIX_W-1:0] bg);
    int a;
    int sum;
    logic [PIX_W-1:0] res;
    a   = int'(fg[31:24]);
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = int'(fg[ch*8 +: 8]) * a + int'(bg[ch*8 +: 8]) * (255 - a);
      res[ch*8 +: 8] = CHAN_W'(sum / 255);
    end
    return res;
  endfunction

  // applies one pixel operation to the shadow framebuffer
  function automatic pixel_result_t apply_pixel_op(input logic [1:0] act,
                                                   input logic signed [11:0] bx,
                                                   input logic signed [11:0] by,
                                                   input logic [7:0] ox,
                                                   input logic [7:0] oy,
                                                   input logic [PIX_W-1:0] color);
    pixel_result_t    r;
    int               col;
    int               row;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] nv;
    r   = '0;
    col = int'(bx) + int'(ox);
    row = int'(by) + int'(oy);
    if (col < 0 || col >= FRAME_WIDTH || row < 0 || row >= FRAME_HEIGHT) return r;
    idx = IDX_W'(row * FRAME_WIDTH + col);
    case (act)
      ACT_PUT: begin
        frame_model[idx] = color;
        r = '{1'b1, idx, color};
      end
      ACT_BLEND: begin
        if (color[31:24] != 8'h00) begin
          nv = blend_over(color, frame_model[idx]);
          frame_model[idx] = nv;
          r = '{1'b1, idx, nv};
        end
      end
      ACT_READ: r = '{1'b0, idx, frame_model[idx]};
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 65536; i++) frame_model[i] = '0;
      expected_px.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          flag_mismatch("unexpected result beat", out_pixel_value, '0);
        end else begin
          want = expected_px.pop_front();
          checked++;
          if (out_written !== want.written)
            flag_mismatch("written", out_written, want.written);
          if (out_pixel_index !== want.index)
            flag_mismatch("pixel_index", out_pixel_index, want.index);
          if (out_pixel_value !== want.value)
            flag_mismatch("pixel_value", out_pixel_value, want.value);
        end
      end
      if (in_valid && !in_stall)
        expected_px.push_back(apply_pixel_op(in_action, in_base_x, in_base_y,
                                             in_offset_x, in_offset_y, in_pixel_color));
    end
    pending = expected_px.size();
  end

endmodule

/* verif/alpha_sprite_pixel_writer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_sprite_pixel_writer_test
// drives pixel operations into the writer with random gaps and back-pressure;
// a checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module alpha_sprite_pixel_writer_test;
  import asp_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // window of beats with no idling on either side
  localparam int CALM_FIRST   = 200;
  localparam int CALM_LAST    = 350;
  // receiver holds off once this many beats have gone in
  localparam int HOLD_AT      = 450;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BEATS = 780;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic signed [11:0] in_base_x;
  logic signed [11:0] in_base_y;
  logic [7:0]         in_offset_x;
  logic [7:0]         in_offset_y;
  logic [PIX_W-1:0]   in_pixel_color;
  logic               out_valid;
  logic               out_stall;
  logic               out_written;
  logic [IDX_W-1:0]   out_pixel_index;
  logic [PIX_W-1:0]   out_pixel_value;

  int err_count;
  int pending;
  int checked;

  // beats accepted so far, split by action
  int sent;
  int n_put, n_blend, n_read, n_unused;
  bit hold_done;

  alpha_sprite_pixel_writer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_base_x       (in_base_x),
    .in_base_y       (in_base_y),
    .in_offset_x     (in_offset_x),
    .in_offset_y     (in_offset_y),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_written     (out_written),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value)
  );

  asp_pixel_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_base_x       (in_base_x),
    .in_base_y       (in_base_y),
    .in_offset_x     (in_offset_x),
    .in_offset_y     (in_offset_y),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_written     (out_written),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value),
    .err_count       (err_count),
    .pending         (pending),
    .checked         (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop: covers the clearing pass over all 65536 store entries plus a very slow run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit in_calm_window();
    return sent >= CALM_FIRST && sent < CALM_LAST;
  endfunction

  // one input beat, with an optional idle gap in front of it
  task automatic offer_pixel_op(input logic [1:0] act, input logic signed [11:0] bx,
                                input logic signed [11:0] by, input logic [7:0] ox,
                                input logic [7:0] oy, input logic [PIX_W-1:0] color);
    int gap;
    gap = 0;
    if (!in_calm_window() && $urandom_range(99) < 16) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_base_x      <= bx;
    in_base_y      <= by;
    in_offset_x    <= ox;
    in_offset_y    <= oy;
    in_pixel_color <= color;
    // payload holds until the beat is taken
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    case (act)
      ACT_PUT:   n_put++;
      ACT_BLEND: n_blend++;
      ACT_READ:  n_read++;
      default:   n_unused++;
    endcase
  endtask

  // receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent >= HOLD_AT) begin
        // long hold-off so the internal queue fills and in_stall rises
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (in_calm_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 16);
      end
    end
  end

  // stimulus
  initial begin
    logic [1:0]         act;
    logic signed [11:0] bx, by;
    logic [7:0]         ox, oy, alpha;
    logic [PIX_W-1:0]   color;
    int                 pick, tc, tr;

    sent = 0; n_put = 0; n_blend = 0; n_read = 0; n_unused = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_PUT;
    in_base_x      = '0;
    in_base_y      = '0;
    in_offset_x    = '0;
    in_offset_y    = '0;
    in_pixel_color = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats; in_stall covers the clearing pass after reset
    offer_pixel_op(ACT_READ,   12'sd0,     12'sd0,     8'd0,   8'd0,   32'h0000_0000);
    offer_pixel_op(ACT_PUT,    12'sd0,     12'sd0,     8'd0,   8'd0,   32'h1234_5678);
    offer_pixel_op(ACT_READ,   12'sd0,     12'sd0,     8'd0,   8'd0,   32'h0000_0000);
    // zero alpha blend leaves the pixel alone
    offer_pixel_op(ACT_BLEND,  12'sd0,     12'sd0,     8'd0,   8'd0,   32'h00FF_FFFF);
    offer_pixel_op(ACT_BLEND,  12'sd0,     12'sd0,     8'd0,   8'd0,   32'h80FF_00FF);
    offer_pixel_op(ACT_READ,   12'sd0,     12'sd0,     8'd0,   8'd0,   32'h0000_0000);
    // full alpha, far corner from base alone
    offer_pixel_op(ACT_BLEND,  12'sd255,   12'sd255,   8'd0,   8'd0,   32'hFFA1_B2C3);
    // far corner from offset alone
    offer_pixel_op(ACT_PUT,    12'sd0,     12'sd0,     8'd255, 8'd255, 32'hFFFF_FFFF);
    offer_pixel_op(ACT_BLEND,  12'sd0,     12'sd0,     8'd255, 8'd255, 32'h0100_0000);
    offer_pixel_op(ACT_READ,   12'sd255,   12'sd255,   8'd0,   8'd0,   32'h0000_0000);
    // clipped writes on every edge and at the field extremes
    offer_pixel_op(ACT_PUT,    -12'sd1,    12'sd0,     8'd0,   8'd0,   32'hDEAD_BEEF);
    offer_pixel_op(ACT_PUT,    12'sd256,   12'sd0,     8'd0,   8'd0,   32'hDEAD_BEEF);
    offer_pixel_op(ACT_PUT,    12'sd2047,  12'sd2047,  8'd255, 8'd255, 32'hDEAD_BEEF);
    offer_pixel_op(ACT_PUT,    -12'sd2048, -12'sd2048, 8'd255, 8'd255, 32'hDEAD_BEEF);
    // negative base pulled back in by the offset, opaque zero still written
    offer_pixel_op(ACT_PUT,    -12'sd255,  -12'sd255,  8'd255, 8'd255, 32'h0000_0000);
    offer_pixel_op(ACT_READ,   12'sd200,   12'sd0,     8'd100, 8'd0,   32'h0000_0000);
    offer_pixel_op(ACT_UNUSED, 12'sd10,    12'sd10,    8'd0,   8'd0,   32'hFFFF_FFFF);
    offer_pixel_op(ACT_UNUSED, -12'sd5,    12'sd10,    8'd0,   8'd0,   32'hFFFF_FFFF);
    offer_pixel_op(ACT_READ,   12'sd10,    12'sd10,    8'd0,   8'd0,   32'h0000_0000);
    offer_pixel_op(ACT_BLEND,  12'sd0,     12'sd255,   8'd0,   8'd0,   32'hFFFF_FFFF);
    offer_pixel_op(ACT_PUT,    12'sd1,     12'sd0,     8'd0,   8'd0,   32'hAA55_AA55);
    offer_pixel_op(ACT_BLEND,  12'sd1,     12'sd0,     8'd0,   8'd0,   32'h7F55_AA00);
    offer_pixel_op(ACT_READ,   12'sd0,     12'sd0,     8'd1,   8'd0,   32'h0000_0000);
    offer_pixel_op(ACT_BLEND,  12'sd3,     -12'sd1,    8'd0,   8'd0,   32'hFF12_3456);

    // random beats, mostly landing in the frame, half of those in a small
    // hot window so blends and reads see earlier writes
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(99);
      if (pick < 35)      act = ACT_PUT;
      else if (pick < 70) act = ACT_BLEND;
      else if (pick < 95) act = ACT_READ;
      else                act = ACT_UNUSED;

      ox = 8'($urandom);
      oy = 8'($urandom);
      if ($urandom_range(99) < 15) begin
        // anywhere in the coordinate space, mostly clipped
        bx = 12'($urandom);
        by = 12'($urandom);
      end else begin
        if ($urandom_range(1) == 1) begin
          tc = 120 + $urandom_range(7);
          tr = 120 + $urandom_range(7);
        end else begin
          tc = $urandom_range(255);
          tr = $urandom_range(255);
        end
        bx = 12'(tc - int'(ox));
        by = 12'(tr - int'(oy));
      end

      pick = $urandom_range(9);
      if (pick < 2)      alpha = 8'h00;
      else if (pick < 4) alpha = 8'hFF;
      else               alpha = 8'($urandom);
      color = {alpha, 24'($urandom)};

      offer_pixel_op(act, bx, by, ox, oy, color);
    end
    in_valid <= 1'b0;

    // drain, then keep watching to catch any stray result beat
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d beats: %0d put, %0d blend, %0d read, %0d unused code",
             sent, n_put, n_blend, n_read, n_unused);
    $display("%0d results compared, including a %0d-cycle receiver hold-off",
             checked, HOLD_CYCLES);
    // a predicted result that never showed up is a failure too
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/asp_pkg.sv
rtl/asp_front.sv
rtl/asp_queue.sv
rtl/asp_back.sv
rtl/alpha_sprite_pixel_writer.sv
verif/asp_pixel_checker.sv
verif/alpha_sprite_pixel_writer_test.sv
